FILE: rtl/irmst_pkg.sv
// Package for the infrared mark/space transmitter.
// Holds the shared types, register codes and reset values; no dependencies.
`default_nettype none

package irmst_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned RegIdxW = 1;

  localparam logic [RegIdxW-1:0] RegCarrierReload = 1'b0;
  localparam logic [RegIdxW-1:0] RegSignalPrescale = 1'b1;

  localparam logic [DurW-1:0] CarrierReloadRst = 16'd1262;
  localparam logic [DurW-1:0] SignalPrescaleRst = 16'd47;
  localparam logic [DurW-1:0] DurMax = 16'hFFFF;

  typedef struct packed {
    logic            has_pair;
    logic [DurW-1:0] off_ticks;
    logic [DurW-1:0] on_ticks;
  } fifo_head_t;

  typedef struct packed {
    logic envelope_on;
    logic carrier_on;
  } timer_flags_t;

endpackage

`default_nettype wire

FILE: rtl/ir_mark_space_transmitter_unit.sv
// Infrared mark/space transmitter: top level with input and result registers.
// An accepted item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle unless m_axis_tready stalls the result register.
// Reset: counters and FIFO pointers clear, envelope idles, registers take defaults.
// Depends on irmst_pkg, irmst_pair_fifo and irmst_timer.
`default_nettype none

module ir_mark_space_transmitter_unit import irmst_pkg::*; #(
  parameter int unsigned FIFO_DEPTH  = 64,
  parameter int unsigned IDLE_PERIOD = 1000,
  localparam int unsigned QueueW = $clog2(FIFO_DEPTH + 1),
  localparam int unsigned OutBits = 4 + QueueW,
  localparam int unsigned OutW = ((OutBits + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [DurW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // on_ticks [15:0], off_ticks [31:16]
  input  wire logic [2*DurW-1:0]   s_axis_tdata,
  // kind [0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // ir_drive, envelope_on, carrier_on, queued_durations, push_rejected, zero pad
  output logic [OutW-1:0]          m_axis_tdata
);

  localparam int unsigned Pairs = FIFO_DEPTH / 2;
  localparam int unsigned PtrW  = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int unsigned CntW  = $clog2(Pairs + 1);

  logic [DurW-1:0] carrier_reload_q;
  logic [DurW-1:0] signal_prescale_q;

  logic            in_valid_q;
  logic            kind_q;
  logic [DurW-1:0] on_q;
  logic [DurW-1:0] off_q;

  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic [OutW-1:0] out_data_d;

  logic            advance;
  logic            fire;
  logic            push;
  logic            pop;
  logic            full;
  logic [CntW-1:0] count_d;
  logic [QueueW-1:0] queued;
  fifo_head_t      head;
  timer_flags_t    flags_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign push          = fire && !kind_q && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_reload_q  <= CarrierReloadRst;
      signal_prescale_q <= SignalPrescaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCarrierReload:  carrier_reload_q  <= cfg_data_i;
        RegSignalPrescale: signal_prescale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      on_q   <= s_axis_tdata[DurW-1:0];
      off_q  <= s_axis_tdata[2*DurW-1:DurW];
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  irmst_pair_fifo #(
    .Pairs(Pairs),
    .PtrW (PtrW),
    .CntW (CntW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_on_i (on_q),
    .push_off_i(off_q),
    .pop_i     (pop),
    .head_o    (head),
    .full_o    (full),
    .count_d_o (count_d)
  );

  irmst_timer #(
    .IdlePeriod(IDLE_PERIOD)
  ) u_timer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (fire && kind_q),
    .carrier_reload_i (carrier_reload_q),
    .signal_prescale_i(signal_prescale_q),
    .head_i           (head),
    .pop_o            (pop),
    .flags_d_o        (flags_d)
  );

  assign queued = QueueW'({count_d, 1'b0});

  always_comb begin
    out_data_d              = '0;
    out_data_d[0]           = flags_d.envelope_on && flags_d.carrier_on;
    out_data_d[1]           = flags_d.envelope_on;
    out_data_d[2]           = flags_d.carrier_on;
    out_data_d[3+:QueueW]   = queued;
    out_data_d[3+QueueW]    = !kind_q && full;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/irmst_pair_fifo.sv
// Duration FIFO that stores mark/space pairs, one pair per memory word.
// Registered memory read with write bypass keeps the head pair ready.
// Depends on irmst_pkg.
`default_nettype none

module irmst_pair_fifo import irmst_pkg::*; #(
  parameter int unsigned Pairs = 32,
  parameter int unsigned PtrW  = 5,
  parameter int unsigned CntW  = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [DurW-1:0] push_on_i,
  input  wire logic [DurW-1:0] push_off_i,
  input  wire logic            pop_i,
  output fifo_head_t           head_o,
  output logic                 full_o,
  output logic [CntW-1:0]      count_d_o
);

  logic [2*DurW-1:0] pair_mem [Pairs];
  logic [2*DurW-1:0] mem_rd_q;
  logic [2*DurW-1:0] byp_data_q;
  logic              byp_q;

  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [2*DurW-1:0] wr_data;
  logic [2*DurW-1:0] head_data;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Pairs - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_data = {push_off_i, push_on_i};

  always_comb begin
    wr_d    = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d    = pop_i ? ptr_inc(rd_q) : rd_q;
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pair_mem[wr_q] <= wr_data;
    end
    mem_rd_q   <= pair_mem[rd_d];
    byp_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
      byp_q   <= push_i && (wr_q == rd_d);
    end
  end

  assign head_data        = byp_q ? byp_data_q : mem_rd_q;
  assign head_o.has_pair  = (count_q != '0);
  assign head_o.on_ticks  = head_data[DurW-1:0];
  assign head_o.off_ticks = head_data[2*DurW-1:DurW];
  assign full_o           = (count_q == CntW'(Pairs));
  assign count_d_o        = count_d;

endmodule

`default_nettype wire

FILE: rtl/irmst_timer.sv
// Carrier, prescale and envelope counters with pair loading at envelope wrap.
// Depends on irmst_pkg.
`default_nettype none

module irmst_timer import irmst_pkg::*; #(
  parameter int unsigned IdlePeriod = 1000
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tick_i,
  input  wire logic [DurW-1:0] carrier_reload_i,
  input  wire logic [DurW-1:0] signal_prescale_i,
  input  wire fifo_head_t      head_i,
  output logic                 pop_o,
  output timer_flags_t         flags_d_o
);

  logic [DurW-1:0] carrier_q, carrier_d;
  logic [DurW-1:0] prescale_q, prescale_d;
  logic [DurW-1:0] env_q, env_d;
  logic [DurW-1:0] env_reload_q, env_reload_d;
  logic [DurW-1:0] mark_q, mark_d;
  logic [DurW:0]   pair_sum;

  assign pair_sum = {1'b0, head_i.on_ticks} + {1'b0, head_i.off_ticks};

  always_comb begin
    carrier_d    = carrier_q;
    prescale_d   = prescale_q;
    env_d        = env_q;
    env_reload_d = env_reload_q;
    mark_d       = mark_q;
    pop_o        = 1'b0;
    if (tick_i) begin
      carrier_d = (carrier_q >= carrier_reload_i) ? '0 : carrier_q + DurW'(1);
      if (prescale_q >= signal_prescale_i) begin
        prescale_d = '0;
        if (env_q >= env_reload_q) begin
          env_d = '0;
          if (head_i.has_pair) begin
            pop_o        = 1'b1;
            env_reload_d = pair_sum[DurW] ? DurMax : pair_sum[DurW-1:0];
            mark_d       = head_i.on_ticks;
          end else begin
            env_reload_d = DurW'(IdlePeriod);
            mark_d       = '0;
          end
        end else begin
          env_d = env_q + DurW'(1);
        end
      end else begin
        prescale_d = prescale_q + DurW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q    <= '0;
      prescale_q   <= '0;
      env_q        <= '0;
      env_reload_q <= DurW'(IdlePeriod);
      mark_q       <= '0;
    end else begin
      carrier_q    <= carrier_d;
      prescale_q   <= prescale_d;
      env_q        <= env_d;
      env_reload_q <= env_reload_d;
      mark_q       <= mark_d;
    end
  end

  assign flags_d_o.envelope_on = (env_d < mark_d);
  assign flags_d_o.carrier_on  = (carrier_d < {2'b00, carrier_reload_i[DurW-1:2]});

endmodule

`default_nettype wire
